@@ src/bmie_pkg.sv @@
package bmie_pkg;

    // default data memory size in bytes
    localparam int DATA_BYTES_DEF = 16384;
    // code space size; a program counter at or above it halts the block
    localparam int CODE_BYTES = 16384;

    // instruction kinds
    localparam logic [4:0] K_PTR_UP   = 5'd0;
    localparam logic [4:0] K_PTR_DOWN = 5'd1;
    localparam logic [4:0] K_JUMP     = 5'd2;
    localparam logic [4:0] K_INC      = 5'd3;
    localparam logic [4:0] K_DEC      = 5'd4;
    localparam logic [4:0] K_ADD      = 5'd5;
    localparam logic [4:0] K_SUB      = 5'd6;
    localparam logic [4:0] K_MUL      = 5'd7;
    localparam logic [4:0] K_DIV      = 5'd8;
    localparam logic [4:0] K_MOD      = 5'd9;
    localparam logic [4:0] K_NEG      = 5'd10;
    localparam logic [4:0] K_AND      = 5'd11;
    localparam logic [4:0] K_OR       = 5'd12;
    localparam logic [4:0] K_XOR      = 5'd13;
    localparam logic [4:0] K_LAND     = 5'd14;
    localparam logic [4:0] K_LOR      = 5'd15;
    localparam logic [4:0] K_NOT      = 5'd16;
    localparam logic [4:0] K_LNOT     = 5'd17;
    localparam logic [4:0] K_MOV      = 5'd18;
    localparam logic [4:0] K_EQ       = 5'd19;
    localparam logic [4:0] K_SHL      = 5'd20;
    localparam logic [4:0] K_LT       = 5'd21;
    localparam logic [4:0] K_GT       = 5'd22;
    localparam logic [4:0] K_SHR      = 5'd23;
    localparam logic [4:0] K_LOAD     = 5'd24;
    localparam logic [4:0] K_OUT      = 5'd25;

    // pointer selects
    localparam logic [1:0] PS_DEST = 2'd0;
    localparam logic [1:0] PS_SRCX = 2'd1;
    localparam logic [1:0] PS_SRCY = 2'd2;

    // operand size codes
    localparam logic [1:0] SZ_B1 = 2'd0;
    localparam logic [1:0] SZ_B2 = 2'd1;
    localparam logic [1:0] SZ_B4 = 2'd2;

    // operations of the iterative unit
    typedef enum logic [1:0] {
        IOP_MUL = 2'd0,
        IOP_DIV = 2'd1,
        IOP_SHL = 2'd2,
        IOP_SHR = 2'd3
    } iter_op_t;

    typedef struct packed {
        logic       start;
        iter_op_t   op;
        logic [6:0] steps;
    } iter_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_sts_t;

    // value mask for an operand size
    function automatic logic [63:0] size_mask(input logic [1:0] sz);
        logic [63:0] m;
        case (sz)
            SZ_B1:   m = 64'h0000_0000_0000_00FF;
            SZ_B2:   m = 64'h0000_0000_0000_FFFF;
            SZ_B4:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // sign bit for an operand size
    function automatic logic [63:0] sign_bit(input logic [1:0] sz);
        logic [63:0] s;
        case (sz)
            SZ_B1:   s = 64'h0000_0000_0000_0080;
            SZ_B2:   s = 64'h0000_0000_0000_8000;
            SZ_B4:   s = 64'h0000_0000_8000_0000;
            default: s = 64'h8000_0000_0000_0000;
        endcase
        return s;
    endfunction

endpackage

@@ src/byte_machine_instruction_executor_top.sv @@
// Byte machine instruction executor: runs one decoded instruction per input beat.
// Input beat: s_tuser carries kind and pointer select, s_tdata the size code,
// flags, jump target and immediate byte. One result beat comes back per
// input beat with status, next pc, halt flag and any emitted value.
// After reset the data memory is cleared one byte a cycle, and s_tready
// stays low until that pass is done.
// Instructions are taken one at a time; s_tready is high only when idle.
// Pointer steps, nop and stopped or overflowing beats finish in decode; load
// writes its immediate byte, jump reads one byte and out reads its bytes.
// An n-byte operation reads each source one byte at a time and writes one
// byte a cycle. Multiply, and divide or modulo by a nonzero divisor, run on
// the shared multiply/divide/shift unit (64 steps, one bit a cycle); shifts
// below the operand width run one step per bit of shift amount. s_tready
// returns in the cycle after the result is loaded into the output register.
// While the receiver stalls, the finished result waits in a staging register
// until the output register frees up, and no new beat is accepted meanwhile.
// An overflow or a pc leaving code space stops the block; later beats get
// the current pc with the halt flag set.
module byte_machine_instruction_executor_top
    import bmie_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // size_code[1:0], signed_flag[2], numeric_flag[3], jump_target[19:4],
    // immediate[27:20], zero[31:28]
    input  logic [31:0] s_tdata,
    // kind[4:0], pointer_select[6:5]
    input  logic [6:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], next_pc[16:1], halted[17], print_valid[18], print_size[20:19],
    // print_value[84:21], zero[87:85]
    output logic [87:0] m_tdata,
    // print_numeric[0]
    output logic [0:0]  m_tuser
);

    localparam int AW = $clog2(DATA_BYTES);
    localparam logic [AW:0] DEPTH = (AW+1)'(DATA_BYTES);
    localparam logic [16:0] CODE_LIM = 17'(CODE_BYTES);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_DEC   = 9'b000000100,
        ST_RDA   = 9'b000001000,
        ST_RDB   = 9'b000010000,
        ST_EXEC  = 9'b000100000,
        ST_WAIT  = 9'b001000000,
        ST_WR    = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t       state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [15:0]  pc_reg, pc_next;
    logic [AW-1:0] dptr_reg, dptr_next;
    logic [AW-1:0] xptr_reg, xptr_next;
    logic [AW-1:0] yptr_reg, yptr_next;
    logic         stopped_reg, stopped_next;

    // latched instruction
    logic [4:0]   kind_reg, kind_next;
    logic [1:0]   psel_reg, psel_next;
    logic [1:0]   sz_reg, sz_next;
    logic         sg_reg, sg_next;
    logic         num_reg, num_next;
    logic [15:0]  tgt_reg, tgt_next;
    logic [7:0]   imm_reg, imm_next;

    logic [3:0]   cnt_reg, cnt_next;
    logic [3:0]   nb_reg, nb_next;
    logic [63:0]  opa_reg, opa_next;
    logic [63:0]  opb_reg, opb_next;
    logic [63:0]  res_reg, res_next;

    // staged result
    logic         st_status_reg, st_status_next;
    logic [15:0]  st_pc_reg, st_pc_next;
    logic         st_halt_reg, st_halt_next;
    logic         st_pv_reg, st_pv_next;
    logic         st_pn_reg, st_pn_next;
    logic [1:0]   st_ps_reg, st_ps_next;
    logic [63:0]  st_val_reg, st_val_next;

    // output register
    logic         m_valid_reg;
    logic [87:0]  m_data_reg;
    logic         m_user_reg;
    logic         out_load;

    // finish request
    logic         fin_go, fin_upd, f_status, f_halt, f_pv, f_pn;
    logic [15:0]  f_pc;
    logic [1:0]   f_ps;
    logic [63:0]  f_val;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    // shared unit
    iter_req_t    it_req;
    iter_sts_t    it_sts;
    logic [63:0]  it_fill;
    logic [63:0]  it_x, it_acc;

    // decode helpers
    logic [3:0]   size_nb;
    logic [63:0]  msk, sbit;
    logic [6:0]   bits;
    logic         use_x, use_y, is_alu, alu_ovf, b_big, a_neg;
    logic [AW-1:0] a_base, sel_ptr, rd_base;
    logic [2:0]   rd_idx;
    logic [63:0]  simple_res;
    logic [15:0]  pc_plus1;

    function automatic logic pc_halts(input logic [15:0] pc);
        return pc[15] || ({1'b0, pc} >= CODE_LIM);
    endfunction

    function automatic logic fits(input logic [AW-1:0] p, input logic [3:0] nb);
        return (nb == 4'd1) || (({1'b0, p} + (AW+1)'(nb)) < DEPTH);
    endfunction

    bmie_mem #(
        .DEPTH (DATA_BYTES),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bmie_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (it_req),
        .a       (opa_reg),
        .b       (opb_reg),
        .fill    (it_fill),
        .sts     (it_sts),
        .x       (it_x),
        .acc     (it_acc)
    );

    // operand decode
    assign size_nb  = 4'd1 << sz_reg;
    assign msk      = size_mask(sz_reg);
    assign sbit     = sign_bit(sz_reg);
    assign bits     = {size_nb, 3'b000};
    assign is_alu   = kind_reg inside {[K_INC:K_SHR]};
    assign use_x    = kind_reg inside {[K_ADD:K_SHR]};
    assign use_y    = use_x && !(kind_reg inside {K_NEG, K_NOT, K_LNOT, K_MOV});
    assign alu_ovf  = !fits(dptr_reg, size_nb) || (use_x && !fits(xptr_reg, size_nb))
                      || (use_y && !fits(yptr_reg, size_nb));
    assign a_base   = use_x ? xptr_reg : dptr_reg;
    assign rd_base  = (state_reg == ST_RDB) ? yptr_reg : a_base;
    assign rd_idx   = 3'(cnt_reg - 4'd1);
    assign b_big    = opb_reg >= 64'(bits);
    assign a_neg    = sg_reg && ((opa_reg & sbit) != '0);
    assign it_fill  = a_neg ? sbit : '0;
    assign pc_plus1 = pc_reg + 16'd1;
    assign sel_ptr  = (psel_reg == PS_DEST) ? dptr_reg :
                      (psel_reg == PS_SRCX) ? xptr_reg : yptr_reg;

    // combinational results
    always_comb begin
        case (kind_reg)
            K_INC:   simple_res = opa_reg + 64'd1;
            K_DEC:   simple_res = opa_reg - 64'd1;
            K_ADD:   simple_res = opa_reg + opb_reg;
            K_SUB:   simple_res = opa_reg - opb_reg;
            K_NEG:   simple_res = 64'd0 - opa_reg;
            K_AND:   simple_res = opa_reg & opb_reg;
            K_OR:    simple_res = opa_reg | opb_reg;
            K_XOR:   simple_res = opa_reg ^ opb_reg;
            K_LAND:  simple_res = {63'd0, (opa_reg != '0) && (opb_reg != '0)};
            K_LOR:   simple_res = {63'd0, (opa_reg != '0) || (opb_reg != '0)};
            K_NOT:   simple_res = ~opa_reg;
            K_LNOT:  simple_res = {63'd0, opa_reg == '0};
            K_MOV:   simple_res = opa_reg;
            K_EQ:    simple_res = {63'd0, opa_reg == opb_reg};
            K_LT:    simple_res = sg_reg ? {63'd0, (opa_reg ^ sbit) < (opb_reg ^ sbit)}
                                         : {63'd0, opa_reg < opb_reg};
            K_GT:    simple_res = sg_reg ? {63'd0, (opa_reg ^ sbit) > (opb_reg ^ sbit)}
                                         : {63'd0, opa_reg > opb_reg};
            default: simple_res = '0;
        endcase
    end

    // memory port mux
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_addr  = dptr_reg;
        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            ST_RDA, ST_RDB: begin
                mem_addr = rd_base + AW'(cnt_reg[2:0]);
            end
            ST_WR: begin
                mem_we    = 1'b1;
                mem_addr  = dptr_reg + AW'(cnt_reg[2:0]);
                mem_wdata = res_reg[{cnt_reg[2:0], 3'b000} +: 8];
            end
            default: begin
                mem_addr = dptr_reg;
            end
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pc_next        = pc_reg;
        dptr_next      = dptr_reg;
        xptr_next      = xptr_reg;
        yptr_next      = yptr_reg;
        stopped_next   = stopped_reg;
        kind_next      = kind_reg;
        psel_next      = psel_reg;
        sz_next        = sz_reg;
        sg_next        = sg_reg;
        num_next       = num_reg;
        tgt_next       = tgt_reg;
        imm_next       = imm_reg;
        cnt_next       = cnt_reg;
        nb_next        = nb_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        res_next       = res_reg;
        st_status_next = st_status_reg;
        st_pc_next     = st_pc_reg;
        st_halt_next   = st_halt_reg;
        st_pv_next     = st_pv_reg;
        st_pn_next     = st_pn_reg;
        st_ps_next     = st_ps_reg;
        st_val_next    = st_val_reg;
        it_req         = '{start: 1'b0, op: IOP_MUL, steps: 7'd0};
        fin_go         = 1'b0;
        fin_upd        = 1'b1;
        f_status       = 1'b0;
        f_pc           = pc_plus1;
        f_halt         = pc_halts(pc_plus1);
        f_pv           = 1'b0;
        f_pn           = 1'b0;
        f_ps           = '0;
        f_val          = '0;

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if ({1'b0, clr_cnt_reg} == DEPTH - (AW+1)'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser[4:0];
                    psel_next  = s_tuser[6:5];
                    sz_next    = s_tdata[1:0];
                    sg_next    = s_tdata[2];
                    num_next   = s_tdata[3];
                    tgt_next   = s_tdata[19:4];
                    imm_next   = s_tdata[27:20];
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cnt_next = '0;
                opa_next = '0;
                opb_next = '0;
                if (stopped_reg) begin
                    fin_go   = 1'b1;
                    fin_upd  = 1'b0;
                    f_status = !pc_halts(pc_reg);
                    f_pc     = pc_reg;
                    f_halt   = 1'b1;
                end else if (kind_reg == K_PTR_UP || kind_reg == K_PTR_DOWN) begin
                    fin_go = 1'b1;
                    if (psel_reg != PS_DEST && psel_reg != PS_SRCX && psel_reg != PS_SRCY) begin
                        f_pc = pc_plus1;
                    end else if ((kind_reg == K_PTR_UP
                                  && {1'b0, sel_ptr} >= DEPTH - (AW+1)'(1))
                                 || (kind_reg == K_PTR_DOWN && sel_ptr == '0)) begin
                        f_status = 1'b1;
                        f_pc     = pc_reg;
                        f_halt   = 1'b1;
                    end else begin
                        if (psel_reg == PS_DEST) begin
                            dptr_next = (kind_reg == K_PTR_UP) ? dptr_reg + AW'(1)
                                                               : dptr_reg - AW'(1);
                        end else if (psel_reg == PS_SRCX) begin
                            xptr_next = (kind_reg == K_PTR_UP) ? xptr_reg + AW'(1)
                                                               : xptr_reg - AW'(1);
                        end else begin
                            yptr_next = (kind_reg == K_PTR_UP) ? yptr_reg + AW'(1)
                                                               : yptr_reg - AW'(1);
                        end
                    end
                end else if (kind_reg == K_JUMP) begin
                    nb_next    = 4'd1;
                    state_next = ST_RDA;
                end else if (is_alu) begin
                    if (alu_ovf) begin
                        fin_go   = 1'b1;
                        f_status = 1'b1;
                        f_pc     = pc_reg;
                        f_halt   = 1'b1;
                    end else begin
                        nb_next    = size_nb;
                        state_next = ST_RDA;
                    end
                end else if (kind_reg == K_LOAD) begin
                    nb_next    = 4'd1;
                    res_next   = {56'd0, imm_reg};
                    state_next = ST_WR;
                end else if (kind_reg == K_OUT) begin
                    if (num_reg && !fits(dptr_reg, size_nb)) begin
                        fin_go   = 1'b1;
                        f_status = 1'b1;
                        f_pc     = pc_reg;
                        f_halt   = 1'b1;
                    end else begin
                        nb_next    = num_reg ? size_nb : 4'd1;
                        state_next = ST_RDA;
                    end
                end else begin
                    fin_go = 1'b1;
                end
            end
            ST_RDA, ST_RDB: begin
                // issue address cnt, capture byte cnt-1
                for (int i = 0; i < 8; i++) begin
                    if (cnt_reg != '0 && rd_idx == 3'(i)) begin
                        if (state_reg == ST_RDA) begin
                            opa_next[8*i +: 8] = mem_rdata;
                        end else begin
                            opb_next[8*i +: 8] = mem_rdata;
                        end
                    end
                end
                if (cnt_reg == nb_reg) begin
                    cnt_next = '0;
                    if (state_reg == ST_RDB) begin
                        state_next = ST_EXEC;
                    end else if (kind_reg == K_JUMP) begin
                        fin_go = 1'b1;
                        if ((mem_rdata != '0) == sg_reg) begin
                            f_pc = tgt_reg + 16'd3;
                        end else begin
                            f_pc = pc_reg + 16'd3;
                        end
                        f_halt = pc_halts(f_pc);
                    end else if (kind_reg == K_OUT) begin
                        fin_go = 1'b1;
                        f_pv   = 1'b1;
                        f_pn   = num_reg;
                        f_ps   = num_reg ? sz_reg : 2'd0;
                        f_val  = opa_next;
                    end else if (use_y) begin
                        state_next = ST_RDB;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_EXEC: begin
                cnt_next   = '0;
                state_next = ST_WR;
                case (kind_reg)
                    K_MUL: begin
                        it_req     = '{start: 1'b1, op: IOP_MUL, steps: 7'd64};
                        state_next = ST_WAIT;
                    end
                    K_DIV, K_MOD: begin
                        if (opb_reg == '0) begin
                            res_next = (kind_reg == K_DIV) ? msk : opa_reg;
                        end else begin
                            it_req     = '{start: 1'b1, op: IOP_DIV, steps: 7'd64};
                            state_next = ST_WAIT;
                        end
                    end
                    K_SHL: begin
                        if (b_big) begin
                            res_next = '0;
                        end else begin
                            it_req     = '{start: 1'b1, op: IOP_SHL,
                                           steps: {1'b0, opb_reg[5:0]}};
                            state_next = ST_WAIT;
                        end
                    end
                    K_SHR: begin
                        if (b_big) begin
                            res_next = a_neg ? msk : '0;
                        end else begin
                            it_req     = '{start: 1'b1, op: IOP_SHR,
                                           steps: {1'b0, opb_reg[5:0]}};
                            state_next = ST_WAIT;
                        end
                    end
                    default: begin
                        res_next = simple_res & msk;
                    end
                endcase
            end
            ST_WAIT: begin
                if (it_sts.done) begin
                    cnt_next   = '0;
                    state_next = ST_WR;
                    if (kind_reg == K_MUL || kind_reg == K_MOD) begin
                        res_next = it_acc & msk;
                    end else begin
                        res_next = it_x & msk;
                    end
                end
            end
            ST_WR: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == nb_reg - 4'd1) begin
                    fin_go = 1'b1;
                    if (kind_reg == K_LOAD) begin
                        f_pc   = pc_reg + 16'd2;
                        f_halt = pc_halts(f_pc);
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // commit a finished instruction
        if (fin_go) begin
            state_next     = ST_DONE;
            st_status_next = f_status;
            st_pc_next     = f_pc;
            st_halt_next   = f_halt;
            st_pv_next     = f_pv;
            st_pn_next     = f_pn;
            st_ps_next     = f_ps;
            st_val_next    = f_val;
            if (fin_upd) begin
                pc_next      = f_pc;
                stopped_next = f_halt;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pc_reg      <= '0;
            dptr_reg    <= '0;
            xptr_reg    <= '0;
            yptr_reg    <= '0;
            stopped_reg <= 1'b0;
            cnt_reg     <= '0;
            nb_reg      <= 4'd1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pc_reg      <= pc_next;
            dptr_reg    <= dptr_next;
            xptr_reg    <= xptr_next;
            yptr_reg    <= yptr_next;
            stopped_reg <= stopped_next;
            cnt_reg     <= cnt_next;
            nb_reg      <= nb_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        psel_reg      <= psel_next;
        sz_reg        <= sz_next;
        sg_reg        <= sg_next;
        num_reg       <= num_next;
        tgt_reg       <= tgt_next;
        imm_reg       <= imm_next;
        opa_reg       <= opa_next;
        opb_reg       <= opb_next;
        res_reg       <= res_next;
        st_status_reg <= st_status_next;
        st_pc_reg     <= st_pc_next;
        st_halt_reg   <= st_halt_next;
        st_pv_reg     <= st_pv_next;
        st_pn_reg     <= st_pn_next;
        st_ps_reg     <= st_ps_next;
        st_val_reg    <= st_val_next;
        if (out_load) begin
            m_data_reg <= {3'd0, st_val_reg, st_ps_reg, st_pv_reg, st_halt_reg,
                           st_pc_reg, st_status_reg};
            m_user_reg <= st_pn_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // no memory writes once stopped
    a_no_write_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> !mem_we)
        else $error("memory written while stopped");

    // program counter moves only when an instruction finishes
    a_pc_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        !fin_go |=> $stable(pc_reg))
        else $error("pc changed outside finish");

    // shared unit runs only while the sequencer waits for it
    a_iter_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        it_sts.busy |-> state_reg == ST_WAIT)
        else $error("iterative unit busy outside wait");

endmodule

@@ src/bmie_mem.sv @@
module bmie_mem
    import bmie_pkg::*;
#(
    parameter int DEPTH = DATA_BYTES_DEF,
    parameter int AW    = $clog2(DATA_BYTES_DEF)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // single port byte ram, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/bmie_iter.sv @@
module bmie_iter
    import bmie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  iter_req_t   req,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] fill,
    output iter_sts_t   sts,
    output logic [63:0] x,
    output logic [63:0] acc
);

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    iter_op_t    op_reg, op_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] fill_reg, fill_next;
    logic [64:0] rem_try;

    // one bit of multiply, divide or shift per cycle
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        fill_next = fill_reg;
        rem_try   = {acc_reg, x_reg[63]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            op_next   = req.op;
            x_next    = a;
            y_next    = b;
            acc_next  = '0;
            fill_next = fill;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 7'd1;
                case (op_reg)
                    IOP_MUL: begin
                        if (y_reg[0]) begin
                            acc_next = acc_reg + x_reg;
                        end
                        x_next = {x_reg[62:0], 1'b0};
                        y_next = {1'b0, y_reg[63:1]};
                    end
                    IOP_DIV: begin
                        if (rem_try >= {1'b0, y_reg}) begin
                            acc_next = 64'(rem_try - {1'b0, y_reg});
                            x_next   = {x_reg[62:0], 1'b1};
                        end else begin
                            acc_next = rem_try[63:0];
                            x_next   = {x_reg[62:0], 1'b0};
                        end
                    end
                    IOP_SHL: begin
                        x_next = {x_reg[62:0], 1'b0};
                    end
                    default: begin
                        x_next = {1'b0, x_reg[63:1]} | fill_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= IOP_MUL;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        fill_reg <= fill_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = busy_reg && (cnt_reg == '0);
    assign x        = x_reg;
    assign acc      = acc_reg;

endmodule
